FILE: sv/itp_pkg.sv
package itp_pkg;

  localparam int ADDR_W      = 64;
  localparam int OUT_W       = 48;
  localparam int SEL_W       = 6;
  localparam int IDX_W       = 3;
  localparam int WIDTH_W     = 7;
  localparam int NUM_SCALARS = 13;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = 2;
  localparam int FIFO_CNT_W  = 3;

  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] MEM_LOAD  = 2'd1;
  localparam logic [1:0] MEM_STORE = 2'd2;

  localparam logic [1:0] FLAG_NONE  = 2'd0;
  localparam logic [1:0] FLAG_READ  = 2'd1;
  localparam logic [1:0] FLAG_WRITE = 2'd2;

  localparam int EV_MICRO    = 0;
  localparam int EV_MACRO    = 1;
  localparam int EV_SIZESUM  = 2;
  localparam int EV_MAXSIZE  = 3;
  localparam int EV_MAXIDX   = 4;
  localparam int EV_MAXOFF   = 5;
  localparam int EV_BRANCHES = 6;
  localparam int EV_LOADS    = 7;
  localparam int EV_STORES   = 8;
  localparam int EV_UNCOND   = 9;
  localparam int EV_COND     = 10;
  localparam int EV_OTHERS   = 11;
  localparam int EV_FUSION   = 12;

  typedef logic [2:0] cat_t;
  localparam cat_t CAT_LOAD   = 3'd0;
  localparam cat_t CAT_STORE  = 3'd1;
  localparam cat_t CAT_UNCOND = 3'd2;
  localparam cat_t CAT_COND   = 3'd3;
  localparam cat_t CAT_OTHER  = 3'd4;

  typedef struct packed {
    logic               is_read;
    logic [SEL_W-1:0]   sel;
    logic [IDX_W-1:0]   idx;
    logic               is_branch;
    cat_t               cat;
    logic               fusion;
    logic [ADDR_W-1:0]  size;
    logic [ADDR_W-1:0]  size_sat;
    logic               size_small;
    logic [4:0]         size_lo;
    logic [WIDTH_W-1:0] width;
    logic [WIDTH_W-1:0] off_bin;
  } itp_entry_t;

endpackage

FILE: sv/itp_in_if.sv
interface itp_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [2:0]  microop_index;
  logic [63:0] instr_address;
  logic [63:0] fallthrough_pc;
  logic [63:0] branch_target;
  logic [1:0]  mem_kind;
  logic [1:0]  flag_use;
  logic [5:0]  counter_select;

  modport source (
    output valid, op, microop_index, instr_address, fallthrough_pc, branch_target,
           mem_kind, flag_use, counter_select,
    input  ready
  );
  modport sink (
    input  valid, op, microop_index, instr_address, fallthrough_pc, branch_target,
           mem_kind, flag_use, counter_select,
    output ready
  );
endinterface

FILE: sv/itp_out_if.sv
interface itp_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] counter_value;

  modport source (output valid, counter_value, input ready);
  modport sink (input valid, counter_value, output ready);
endinterface

FILE: sv/itp_front.sv
module itp_front #(
  parameter int COUNTER_BITS = 48,
  parameter int OFFSET_BINS  = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  itp_in_if.sink              in_ch,
  output itp_pkg::itp_entry_t q_data,
  output logic                q_valid,
  input  logic                q_ready
);

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam logic [itp_pkg::WIDTH_W-1:0] OB_LIMIT = itp_pkg::WIDTH_W'(OFFSET_BINS);
  localparam logic [itp_pkg::WIDTH_W-1:0] OB_LAST  = itp_pkg::WIDTH_W'(OFFSET_BINS - 1);

  logic s1_v_r, s2_v_r, s3_v_r;
  logic s1_rdy, s2_rdy, s3_rdy;
  logic last_wrote_r;

  itp_pkg::itp_entry_t e_in, s2_in;
  itp_pkg::itp_entry_t s1_e_r, s2_e_r, s3_e_r;
  logic [itp_pkg::ADDR_W-1:0] diff_in, s1_diff_r, s2_dist_r;
  logic [7:0]       s3_nz_r, nz_in;
  logic [7:0][2:0]  s3_pos_r, pos_in;
  logic [5:0]       msb;
  logic [itp_pkg::WIDTH_W-1:0] width;

  assign s3_rdy = !s3_v_r || q_ready;
  assign s2_rdy = !s2_v_r || s3_rdy;
  assign s1_rdy = !s1_v_r || s2_rdy;
  assign in_ch.ready = s1_rdy;

  always_comb begin
    e_in = '0;
    e_in.is_read   = in_ch.op == itp_pkg::OP_READ;
    e_in.sel       = in_ch.counter_select;
    e_in.idx       = in_ch.microop_index;
    e_in.is_branch = in_ch.branch_target != '0;
    e_in.size      = in_ch.fallthrough_pc - in_ch.instr_address;
    e_in.fusion    = e_in.is_branch && in_ch.flag_use == itp_pkg::FLAG_READ && last_wrote_r;
    priority if (in_ch.mem_kind == itp_pkg::MEM_LOAD) begin
      e_in.cat = itp_pkg::CAT_LOAD;
    end else if (in_ch.mem_kind == itp_pkg::MEM_STORE) begin
      e_in.cat = itp_pkg::CAT_STORE;
    end else if (e_in.is_branch && in_ch.flag_use == itp_pkg::FLAG_NONE) begin
      e_in.cat = itp_pkg::CAT_UNCOND;
    end else if (e_in.is_branch && in_ch.flag_use == itp_pkg::FLAG_READ) begin
      e_in.cat = itp_pkg::CAT_COND;
    end else begin
      e_in.cat = itp_pkg::CAT_OTHER;
    end
    diff_in = in_ch.instr_address - in_ch.branch_target;
  end

  always_comb begin
    s2_in = s1_e_r;
    s2_in.size_sat   = (s1_e_r.size > itp_pkg::ADDR_W'(CNT_MAX)) ?
                       itp_pkg::ADDR_W'(CNT_MAX) : s1_e_r.size;
    s2_in.size_small = s1_e_r.size[itp_pkg::ADDR_W-1:5] == '0;
    s2_in.size_lo    = s1_e_r.size[4:0];
  end

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      nz_in[g]  = |s2_dist_r[8*g +: 8];
      pos_in[g] = 3'd0;
      for (int b = 0; b < 8; b++) begin
        if (s2_dist_r[8*g + b]) begin
          pos_in[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    msb = 6'd0;
    for (int g = 0; g < 8; g++) begin
      if (s3_nz_r[g]) begin
        msb = {3'(g), s3_pos_r[g]};
      end
    end
    width = (|s3_nz_r) ? itp_pkg::WIDTH_W'(msb) + itp_pkg::WIDTH_W'(2) : itp_pkg::WIDTH_W'(1);
    q_data = s3_e_r;
    q_data.width   = width;
    q_data.off_bin = (width > OB_LIMIT) ? OB_LAST : width - itp_pkg::WIDTH_W'(1);
  end

  assign q_valid = s3_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      s2_v_r       <= 1'b0;
      s3_v_r       <= 1'b0;
      last_wrote_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_rdy) begin
        s2_v_r <= s1_v_r;
      end
      if (s3_rdy) begin
        s3_v_r <= s2_v_r;
      end
      if (in_ch.valid && s1_rdy && in_ch.op == itp_pkg::OP_RECORD) begin
        last_wrote_r <= in_ch.flag_use == itp_pkg::FLAG_WRITE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_ch.valid) begin
      s1_e_r    <= e_in;
      s1_diff_r <= diff_in;
    end
    if (s2_rdy && s1_v_r) begin
      s2_e_r    <= s2_in;
      s2_dist_r <= s1_diff_r[itp_pkg::ADDR_W-1] ? -s1_diff_r : s1_diff_r;
    end
    if (s3_rdy && s2_v_r) begin
      s3_e_r   <= s2_e_r;
      s3_nz_r  <= nz_in;
      s3_pos_r <= pos_in;
    end
  end

endmodule

FILE: sv/itp_fifo.sv
module itp_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  itp_pkg::itp_entry_t wr_data,
  input  logic                wr_valid,
  output logic                wr_ready,
  output itp_pkg::itp_entry_t rd_data,
  output logic                rd_valid,
  input  logic                rd_ready
);

  itp_pkg::itp_entry_t mem_r [itp_pkg::FIFO_DEPTH];
  logic [itp_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [itp_pkg::FIFO_CNT_W-1:0] cnt_r;
  logic push, pop;

  assign wr_ready = cnt_r != itp_pkg::FIFO_CNT_W'(itp_pkg::FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= itp_pkg::FIFO_CNT_W'(itp_pkg::FIFO_DEPTH))
    else $error("queue occupancy beyond depth");

  a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("queue occupancy did not advance on push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == itp_pkg::FIFO_CNT_W'(itp_pkg::FIFO_DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step with occupancy");

endmodule

FILE: sv/itp_back.sv
module itp_back #(
  parameter int COUNTER_BITS = 48,
  parameter int MICROOP_BINS = 6,
  parameter int SIZE_BINS    = 12,
  parameter int OFFSET_BINS  = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  itp_pkg::itp_entry_t e,
  input  logic                ev,
  output logic                e_ready,
  itp_out_if.source           out_ch
);

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
  localparam int MOP_BASE  = itp_pkg::NUM_SCALARS;
  localparam int SIZE_BASE = MOP_BASE + MICROOP_BINS;
  localparam int OFF_BASE  = SIZE_BASE + SIZE_BINS;

  logic [COUNTER_BITS-1:0] scal_r   [itp_pkg::NUM_SCALARS];
  logic [COUNTER_BITS-1:0] scal_nxt [itp_pkg::NUM_SCALARS];
  logic [COUNTER_BITS-1:0] mop_r    [MICROOP_BINS];
  logic [COUNTER_BITS-1:0] mop_nxt  [MICROOP_BINS];
  logic [COUNTER_BITS-1:0] sizeb_r  [SIZE_BINS];
  logic [COUNTER_BITS-1:0] sizeb_nxt[SIZE_BINS];
  logic [COUNTER_BITS-1:0] off_r    [OFFSET_BINS];
  logic [COUNTER_BITS-1:0] off_nxt  [OFFSET_BINS];

  logic out_v_r;
  logic [itp_pkg::OUT_W-1:0] out_val_r;
  logic upd, pop, macro;
  logic [itp_pkg::ADDR_W:0] sum;
  logic [COUNTER_BITS-1:0] rd_val;
  logic [6:0] sel7;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign upd     = ev && !e.is_read;
  assign pop     = ev && (!e.is_read || !out_v_r || out_ch.ready);
  assign e_ready = !e.is_read || !out_v_r || out_ch.ready;
  assign macro   = e.idx == itp_pkg::IDX_W'(1);
  assign sum     = (itp_pkg::ADDR_W + 1)'(scal_r[itp_pkg::EV_SIZESUM]) +
                   (itp_pkg::ADDR_W + 1)'(e.size);

  always_comb begin
    scal_nxt = scal_r;
    if (upd) begin
      scal_nxt[itp_pkg::EV_MICRO] = sat_inc(scal_r[itp_pkg::EV_MICRO]);
      if (macro) begin
        scal_nxt[itp_pkg::EV_MACRO]   = sat_inc(scal_r[itp_pkg::EV_MACRO]);
        scal_nxt[itp_pkg::EV_SIZESUM] = (sum > (itp_pkg::ADDR_W + 1)'(CNT_MAX)) ?
                                        CNT_MAX : sum[COUNTER_BITS-1:0];
      end
      if (e.size_sat[COUNTER_BITS-1:0] > scal_r[itp_pkg::EV_MAXSIZE]) begin
        scal_nxt[itp_pkg::EV_MAXSIZE] = e.size_sat[COUNTER_BITS-1:0];
      end
      if (COUNTER_BITS'(e.idx) > scal_r[itp_pkg::EV_MAXIDX]) begin
        scal_nxt[itp_pkg::EV_MAXIDX] = COUNTER_BITS'(e.idx);
      end
      if (e.is_branch) begin
        scal_nxt[itp_pkg::EV_BRANCHES] = sat_inc(scal_r[itp_pkg::EV_BRANCHES]);
        if (COUNTER_BITS'(e.width) > scal_r[itp_pkg::EV_MAXOFF]) begin
          scal_nxt[itp_pkg::EV_MAXOFF] = COUNTER_BITS'(e.width);
        end
      end
      unique case (e.cat)
        itp_pkg::CAT_LOAD:   scal_nxt[itp_pkg::EV_LOADS]  = sat_inc(scal_r[itp_pkg::EV_LOADS]);
        itp_pkg::CAT_STORE:  scal_nxt[itp_pkg::EV_STORES] = sat_inc(scal_r[itp_pkg::EV_STORES]);
        itp_pkg::CAT_UNCOND: scal_nxt[itp_pkg::EV_UNCOND] = sat_inc(scal_r[itp_pkg::EV_UNCOND]);
        itp_pkg::CAT_COND:   scal_nxt[itp_pkg::EV_COND]   = sat_inc(scal_r[itp_pkg::EV_COND]);
        default:             scal_nxt[itp_pkg::EV_OTHERS] = sat_inc(scal_r[itp_pkg::EV_OTHERS]);
      endcase
      if (e.fusion) begin
        scal_nxt[itp_pkg::EV_FUSION] = sat_inc(scal_r[itp_pkg::EV_FUSION]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MICROOP_BINS; k++) begin
      mop_nxt[k] = (upd && 5'(e.idx) == 5'(k + 1)) ? sat_inc(mop_r[k]) : mop_r[k];
    end
    for (int k = 0; k < SIZE_BINS; k++) begin
      sizeb_nxt[k] = (upd && macro && e.size_small && e.size_lo == 5'(k + 1)) ?
                     sat_inc(sizeb_r[k]) : sizeb_r[k];
    end
    for (int k = 0; k < OFFSET_BINS; k++) begin
      off_nxt[k] = (upd && e.is_branch && e.off_bin == itp_pkg::WIDTH_W'(k)) ?
                   sat_inc(off_r[k]) : off_r[k];
    end
  end

  always_comb begin
    sel7   = 7'(e.sel);
    rd_val = '0;
    for (int k = 0; k < itp_pkg::NUM_SCALARS; k++) begin
      if (sel7 == 7'(k)) begin
        rd_val = scal_r[k];
      end
    end
    for (int k = 0; k < MICROOP_BINS; k++) begin
      if (sel7 == 7'(MOP_BASE + k)) begin
        rd_val = mop_r[k];
      end
    end
    for (int k = 0; k < SIZE_BINS; k++) begin
      if (sel7 == 7'(SIZE_BASE + k)) begin
        rd_val = sizeb_r[k];
      end
    end
    for (int k = 0; k < OFFSET_BINS; k++) begin
      if (sel7 == 7'(OFF_BASE + k)) begin
        rd_val = off_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < itp_pkg::NUM_SCALARS; k++) begin
        scal_r[k] <= '0;
      end
      for (int k = 0; k < MICROOP_BINS; k++) begin
        mop_r[k] <= '0;
      end
      for (int k = 0; k < SIZE_BINS; k++) begin
        sizeb_r[k] <= '0;
      end
      for (int k = 0; k < OFFSET_BINS; k++) begin
        off_r[k] <= '0;
      end
      out_v_r <= 1'b0;
    end else begin
      scal_r  <= scal_nxt;
      mop_r   <= mop_nxt;
      sizeb_r <= sizeb_nxt;
      off_r   <= off_nxt;
      if (pop && e.is_read) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && e.is_read) begin
      out_val_r <= (64'(rd_val) > 64'(itp_pkg::OUT_MAX)) ?
                   itp_pkg::OUT_MAX : itp_pkg::OUT_W'(rd_val);
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.counter_value = out_val_r;

  a_macro_le_micro: assert property (@(posedge clk) disable iff (!rst_n)
    scal_r[itp_pkg::EV_MACRO] <= scal_r[itp_pkg::EV_MICRO])
    else $error("macro-op count exceeds micro-op count");

  a_fusion_le_branch: assert property (@(posedge clk) disable iff (!rst_n)
    scal_r[itp_pkg::EV_FUSION] <= scal_r[itp_pkg::EV_BRANCHES])
    else $error("fusion count exceeds branch count");

  a_maxidx_range: assert property (@(posedge clk) disable iff (!rst_n)
    scal_r[itp_pkg::EV_MAXIDX] <= COUNTER_BITS'(7))
    else $error("maximum micro-op index out of range");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(pop && e.is_read))
    else $error("result raised without a read transaction");

endmodule

FILE: sv/instruction_trace_profiler.sv
// Instruction trace profiler.
// in_ch carries one transaction per cycle unless stalled: op 0 is a micro-op trace
// record that updates the saturating counters and histograms, op 1 reads the counter
// picked by counter_select. out_ch returns one transaction, counter_value, for each read
// and nothing for records. Throughput: one transaction per cycle, sustained, for records
// and reads alike while out_ch is ready. A read's result passes through three front
// stages for size, branch distance and leading-one search, then the queue entry, then
// the counter read into the output register. A read sees every record accepted before it.
// Reset (rst_n low at a clock edge) clears all counters, the flag-write history and the
// pipeline at that edge; the block accepts input from the next cycle on.
// When out_ch stalls, the output register holds its result while records keep flowing
// until the next read reaches the back; that read waits at the head of the 4-entry queue,
// the queue and the three front stages fill behind it, and then in_ch ready drops until
// the receiver takes the waiting result.
module instruction_trace_profiler #(
  parameter int COUNTER_BITS = 48,
  parameter int MICROOP_BINS = 6,
  parameter int SIZE_BINS    = 12,
  parameter int OFFSET_BINS  = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  itp_in_if.sink    in_ch,
  itp_out_if.source out_ch
);

  itp_pkg::itp_entry_t fq_data, qb_data;
  logic fq_valid, fq_ready, qb_valid, qb_ready;

  itp_front #(
    .COUNTER_BITS (COUNTER_BITS),
    .OFFSET_BINS  (OFFSET_BINS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_data  (fq_data),
    .q_valid (fq_valid),
    .q_ready (fq_ready)
  );

  itp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_data  (fq_data),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .rd_data  (qb_data),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready)
  );

  itp_back #(
    .COUNTER_BITS (COUNTER_BITS),
    .MICROOP_BINS (MICROOP_BINS),
    .SIZE_BINS    (SIZE_BINS),
    .OFFSET_BINS  (OFFSET_BINS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .e       (qb_data),
    .ev      (qb_valid),
    .e_ready (qb_ready),
    .out_ch  (out_ch)
  );

endmodule

FILE: sim/itp_checker.sv
module itp_checker #(
  parameter int COUNTER_BITS = 48,
  parameter int MICROOP_BINS = 6,
  parameter int SIZE_BINS    = 12,
  parameter int OFFSET_BINS  = 24
) (
  input  logic clk,
  input  logic rst_n,
  itp_in_if    in_mon,
  itp_out_if   out_mon,
  output int   fails,
  output int   pending
);

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  localparam cnt_t CNT_MAX   = '1;
  localparam int   MOP_BASE  = itp_pkg::NUM_SCALARS;
  localparam int   SIZE_BASE = MOP_BASE + MICROOP_BINS;
  localparam int   OFF_BASE  = SIZE_BASE + SIZE_BINS;

  cnt_t                      events    [itp_pkg::NUM_SCALARS];
  cnt_t                      uop_hist  [MICROOP_BINS];
  cnt_t                      size_hist [SIZE_BINS];
  cnt_t                      off_hist  [OFFSET_BINS];
  logic                      prev_flag_write;
  logic [itp_pkg::OUT_W-1:0] read_values[$];
  logic [itp_pkg::OUT_W-1:0] want;

  function automatic cnt_t bump(cnt_t c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic cnt_t sum_sat(cnt_t c, logic [63:0] v);
    cnt_t room;
    room = CNT_MAX - c;
    if (v > 64'(room)) return CNT_MAX;
    return c + cnt_t'(v);
  endfunction

  function automatic cnt_t max_of(cnt_t c, logic [63:0] v);
    logic [63:0] clip;
    clip = (v > 64'(CNT_MAX)) ? 64'(CNT_MAX) : v;
    return (clip > 64'(c)) ? cnt_t'(clip) : c;
  endfunction

  function automatic logic [itp_pkg::WIDTH_W-1:0] branch_width(logic [63:0] addr,
                                                               logic [63:0] target);
    logic [63:0] diff;
    logic [63:0] distance;
    diff = addr - target;
    distance = diff[63] ? (64'd0 - diff) : diff;
    if (distance == 64'd0) return itp_pkg::WIDTH_W'(1);
    for (int b = 63; b >= 0; b--) begin
      if (distance[b]) return itp_pkg::WIDTH_W'(b + 2);
    end
    return itp_pkg::WIDTH_W'(1);
  endfunction

  function automatic logic [itp_pkg::OUT_W-1:0] counter_at(logic [itp_pkg::SEL_W-1:0] sel);
    int   s;
    cnt_t v;
    s = int'(sel);
    v = '0;
    foreach (events[k]) begin
      if (s == k) v = events[k];
    end
    foreach (uop_hist[k]) begin
      if (s == MOP_BASE + k) v = uop_hist[k];
    end
    foreach (size_hist[k]) begin
      if (s == SIZE_BASE + k) v = size_hist[k];
    end
    foreach (off_hist[k]) begin
      if (s == OFF_BASE + k) v = off_hist[k];
    end
    if (64'(v) > 64'(itp_pkg::OUT_MAX)) return itp_pkg::OUT_MAX;
    return itp_pkg::OUT_W'(v);
  endfunction

  function automatic void take_record(logic [2:0] idx, logic [63:0] addr, logic [63:0] fall,
                                      logic [63:0] target, logic [1:0] mem, logic [1:0] flags);
    logic [63:0]                 ins_size;
    logic [itp_pkg::WIDTH_W-1:0] width;
    logic                        taken;
    int                          bin;
    ins_size = fall - addr;
    taken = target != 64'd0;
    events[itp_pkg::EV_MICRO] = bump(events[itp_pkg::EV_MICRO]);
    if (idx == 3'd1) begin
      events[itp_pkg::EV_MACRO] = bump(events[itp_pkg::EV_MACRO]);
      events[itp_pkg::EV_SIZESUM] = sum_sat(events[itp_pkg::EV_SIZESUM], ins_size);
      foreach (size_hist[k]) begin
        if (ins_size == 64'(k + 1)) size_hist[k] = bump(size_hist[k]);
      end
    end
    events[itp_pkg::EV_MAXIDX] = max_of(events[itp_pkg::EV_MAXIDX], 64'(idx));
    events[itp_pkg::EV_MAXSIZE] = max_of(events[itp_pkg::EV_MAXSIZE], ins_size);
    foreach (uop_hist[k]) begin
      if (int'(idx) == k + 1) uop_hist[k] = bump(uop_hist[k]);
    end
    if (taken) begin
      width = branch_width(addr, target);
      bin = (int'(width) > OFFSET_BINS) ? OFFSET_BINS - 1 : int'(width) - 1;
      events[itp_pkg::EV_MAXOFF] = max_of(events[itp_pkg::EV_MAXOFF], 64'(width));
      foreach (off_hist[k]) begin
        if (k == bin) off_hist[k] = bump(off_hist[k]);
      end
      events[itp_pkg::EV_BRANCHES] = bump(events[itp_pkg::EV_BRANCHES]);
    end
    if (mem == itp_pkg::MEM_LOAD) begin
      events[itp_pkg::EV_LOADS] = bump(events[itp_pkg::EV_LOADS]);
    end else if (mem == itp_pkg::MEM_STORE) begin
      events[itp_pkg::EV_STORES] = bump(events[itp_pkg::EV_STORES]);
    end else if (taken && flags == itp_pkg::FLAG_NONE) begin
      events[itp_pkg::EV_UNCOND] = bump(events[itp_pkg::EV_UNCOND]);
    end else if (taken && flags == itp_pkg::FLAG_READ) begin
      events[itp_pkg::EV_COND] = bump(events[itp_pkg::EV_COND]);
    end else begin
      events[itp_pkg::EV_OTHERS] = bump(events[itp_pkg::EV_OTHERS]);
    end
    if (taken && flags == itp_pkg::FLAG_READ && prev_flag_write) begin
      events[itp_pkg::EV_FUSION] = bump(events[itp_pkg::EV_FUSION]);
    end
    prev_flag_write = flags == itp_pkg::FLAG_WRITE;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (events[i]) events[i] = '0;
      foreach (uop_hist[i]) uop_hist[i] = '0;
      foreach (size_hist[i]) size_hist[i] = '0;
      foreach (off_hist[i]) off_hist[i] = '0;
      prev_flag_write = 1'b0;
      read_values.delete();
      fails = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (read_values.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time,
                   out_mon.counter_value);
          fails++;
        end else begin
          want = read_values.pop_front();
          if (out_mon.counter_value !== want) begin
            $display("%0t: counter_value mismatch: expected %h, got %h", $time, want,
                     out_mon.counter_value);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.op == itp_pkg::OP_READ) begin
          read_values.push_back(counter_at(in_mon.counter_select));
        end else begin
          take_record(in_mon.microop_index, in_mon.instr_address, in_mon.fallthrough_pc,
                      in_mon.branch_target, in_mon.mem_kind, in_mon.flag_use);
        end
      end
    end
    pending = read_values.size();
  end

endmodule

FILE: sim/testbench.sv
module testbench;

  localparam int COUNTER_BITS = 48;
  localparam int MICROOP_BINS = 6;
  localparam int SIZE_BINS    = 12;
  localparam int OFFSET_BINS  = 24;

  localparam logic [1:0] MEM_NONE   = 2'd0;
  localparam logic [1:0] MEM_BAD    = 2'd3;
  localparam logic [1:0] FLAG_OTHER = 2'd3;

  typedef struct {
    logic        op;
    logic [2:0]  idx;
    logic [63:0] addr;
    logic [63:0] fall;
    logic [63:0] target;
    logic [1:0]  mem;
    logic [1:0]  flags;
    logic [5:0]  sel;
  } trace_item_t;

  logic clk;
  logic rst_n;
  int   in_idle;
  int   out_idle;
  int   items_sent;
  int   fails;
  int   pending;

  itp_in_if  in_w ();
  itp_out_if out_w ();

  instruction_trace_profiler #(
    .COUNTER_BITS(COUNTER_BITS),
    .MICROOP_BINS(MICROOP_BINS),
    .SIZE_BINS   (SIZE_BINS),
    .OFFSET_BINS (OFFSET_BINS)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_w),
    .out_ch(out_w)
  );

  itp_checker #(
    .COUNTER_BITS(COUNTER_BITS),
    .MICROOP_BINS(MICROOP_BINS),
    .SIZE_BINS   (SIZE_BINS),
    .OFFSET_BINS (OFFSET_BINS)
  ) checker_i (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_mon (in_w),
    .out_mon(out_w),
    .fails  (fails),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  initial begin
    out_w.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_w.ready <= rst_n && ($urandom_range(99) >= out_idle);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic trace_item_t make_record(logic [2:0] idx, logic [63:0] addr,
                                              logic [63:0] ins_size, logic [63:0] target,
                                              logic [1:0] mem, logic [1:0] flags);
    trace_item_t t;
    t.op = itp_pkg::OP_RECORD;
    t.idx = idx;
    t.addr = addr;
    t.fall = addr + ins_size;
    t.target = target;
    t.mem = mem;
    t.flags = flags;
    t.sel = 6'($urandom_range(63));
    return t;
  endfunction

  function automatic trace_item_t make_read(logic [5:0] sel);
    trace_item_t t;
    t = make_record(3'($urandom_range(7)), rand64(), rand64(), rand64(),
                    2'($urandom_range(3)), 2'($urandom_range(3)));
    t.op = itp_pkg::OP_READ;
    t.sel = sel;
    return t;
  endfunction

  function automatic logic [63:0] pick_size(bit allow_huge);
    int r;
    r = $urandom_range(99);
    if (r < 70) return 64'($urandom_range(1, SIZE_BINS));
    if (r < 78) return 64'd0;
    if (r < 88) return 64'($urandom_range(SIZE_BINS + 1, 40));
    if (r < 99 || !allow_huge) return 64'($urandom_range(41, 100000));
    return rand64();
  endfunction

  function automatic logic [63:0] pick_target(logic [63:0] addr);
    int          r;
    int          k;
    logic [63:0] mag;
    r = $urandom_range(99);
    if (r < 40) return 64'd0;
    if (r < 43) return addr + 64'h8000_0000_0000_0000;
    if (r < 46) return addr;
    if (r < 50) return rand64();
    k = $urandom_range(0, 63);
    mag = rand64() >> (63 - k);
    return $urandom_range(1) ? addr + mag : addr - mag;
  endfunction

  task automatic drive_item(input trace_item_t t);
    while ($urandom_range(99) < in_idle) begin
      in_w.valid <= 1'b0;
      @(negedge clk);
    end
    in_w.valid          <= 1'b1;
    in_w.op             <= t.op;
    in_w.microop_index  <= t.idx;
    in_w.instr_address  <= t.addr;
    in_w.fallthrough_pc <= t.fall;
    in_w.branch_target  <= t.target;
    in_w.mem_kind       <= t.mem;
    in_w.flag_use       <= t.flags;
    in_w.counter_select <= t.sel;
    @(posedge clk);
    while (!in_w.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_macro(bit allow_huge);
    int          n;
    logic [63:0] addr;
    logic [63:0] ins_size;
    logic [63:0] target;
    n = $urandom_range(1, MICROOP_BINS - 2);
    addr = rand64();
    ins_size = pick_size(allow_huge);
    for (int i = 1; i <= n; i++) begin
      target = (i == n) ? pick_target(addr) : 64'd0;
      drive_item(make_record(3'(i), addr, ins_size, target,
                             (target != 64'd0) ? MEM_NONE : 2'($urandom_range(2)),
                             2'($urandom_range(2))));
    end
  endtask

  task automatic send_fusion_pair();
    logic [63:0] addr;
    int          r;
    addr = rand64();
    drive_item(make_record(3'd1, addr, pick_size(1'b0), 64'd0, MEM_NONE,
                           itp_pkg::FLAG_WRITE));
    r = $urandom_range(99);
    if (r < 15) begin
      drive_item(make_read(6'($urandom_range(63))));
    end else if (r < 25) begin
      drive_item(make_record(3'd1, rand64(), pick_size(1'b0), 64'd0, itp_pkg::MEM_LOAD,
                             2'($urandom_range(3))));
    end
    addr = addr + 64'd4;
    drive_item(make_record(3'd1, addr, pick_size(1'b0), addr - 64'($urandom_range(1, 4096)),
                           MEM_NONE, itp_pkg::FLAG_READ));
  endtask

  task automatic run_random(input int upto, input bit allow_huge);
    int r;
    while (items_sent < upto) begin
      r = $urandom_range(99);
      if (r < 20) begin
        drive_item(make_read(6'($urandom_range(63))));
      end else if (r < 30) begin
        send_fusion_pair();
      end else if (r < 38) begin
        drive_item(make_record(3'($urandom_range(7)), rand64(), rand64(), rand64(),
                               2'($urandom_range(3)), 2'($urandom_range(3))));
      end else begin
        send_macro(allow_huge);
      end
    end
  endtask

  initial begin
    in_w.valid          = 1'b0;
    in_w.op             = itp_pkg::OP_RECORD;
    in_w.microop_index  = '0;
    in_w.instr_address  = '0;
    in_w.fallthrough_pc = '0;
    in_w.branch_target  = '0;
    in_w.mem_kind       = MEM_NONE;
    in_w.flag_use       = itp_pkg::FLAG_NONE;
    in_w.counter_select = '0;
    rst_n      = 1'b0;
    in_idle    = 32;
    out_idle   = 50;
    items_sent = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    drive_item(make_read(6'(itp_pkg::EV_MICRO)));
    drive_item(make_record(3'd1, 64'd0, 64'd1, 64'd0, MEM_NONE, itp_pkg::FLAG_NONE));
    drive_item(make_record(3'(MICROOP_BINS), 64'h100, 64'(SIZE_BINS), 64'd0,
                           itp_pkg::MEM_LOAD, itp_pkg::FLAG_NONE));
    drive_item(make_record(3'd0, 64'h200, 64'd4, 64'd0, itp_pkg::MEM_STORE,
                           itp_pkg::FLAG_NONE));
    drive_item(make_record(3'd7, 64'h300, 64'd0, 64'd0, MEM_NONE, FLAG_OTHER));
    drive_item(make_record(3'd1, 64'h400, 64'(SIZE_BINS + 1), 64'd0, MEM_BAD,
                           itp_pkg::FLAG_NONE));
    drive_item(make_read(6'(itp_pkg::EV_MAXSIZE)));
    drive_item(make_record(3'd1, 64'h500, 64'd2, 64'h500, MEM_NONE, itp_pkg::FLAG_NONE));
    drive_item(make_record(3'd1, 64'h600, 64'd3, 64'd0, MEM_NONE, itp_pkg::FLAG_WRITE));
    drive_item(make_record(3'd1, 64'h603, 64'd2, 64'h608, MEM_NONE, itp_pkg::FLAG_READ));
    drive_item(make_record(3'd1, 64'h700, 64'd4, 64'h700 + (64'd1 << 40), MEM_NONE,
                           itp_pkg::FLAG_NONE));
    drive_item(make_read(6'(itp_pkg::EV_MAXOFF)));
    drive_item(make_record(3'd1, 64'h1000, 64'd4, 64'h8000_0000_0000_1000, MEM_NONE,
                           itp_pkg::FLAG_READ));
    drive_item(make_record(3'd1, '1, 64'd4, 64'd1, MEM_NONE, FLAG_OTHER));
    drive_item(make_record(3'd2, 64'd0, '1, 64'd0, MEM_NONE, itp_pkg::FLAG_NONE));
    drive_item(make_read(6'(itp_pkg::EV_SIZESUM)));
    drive_item(make_read(6'(itp_pkg::EV_MAXSIZE)));
    drive_item(make_read(6'(itp_pkg::EV_FUSION)));
    drive_item(make_read(6'(itp_pkg::NUM_SCALARS)));
    drive_item(make_read(6'(itp_pkg::NUM_SCALARS + MICROOP_BINS + SIZE_BINS - 1)));
    drive_item(make_read(6'(itp_pkg::NUM_SCALARS + MICROOP_BINS + SIZE_BINS +
                            OFFSET_BINS - 1)));
    drive_item(make_read(6'(itp_pkg::NUM_SCALARS + MICROOP_BINS + SIZE_BINS +
                            OFFSET_BINS)));
    drive_item(make_read(6'd63));

    run_random(450, 1'b0);
    in_idle  = 50;
    out_idle = 32;
    run_random(900, 1'b0);
    in_idle  = 0;
    out_idle = 0;
    run_random(1350, 1'b1);

    in_w.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/itp_pkg.sv
sv/itp_in_if.sv
sv/itp_out_if.sv
sv/itp_front.sv
sv/itp_fifo.sv
sv/itp_back.sv
sv/instruction_trace_profiler.sv
sim/itp_checker.sv
sim/testbench.sv
